// File: design/egcd_pkg.sv
// shared types and constants for the extended gcd unit
package egcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;
    localparam int CNT_WIDTH  = $clog2(MAG_WIDTH + 1);

    typedef logic [MAG_WIDTH-1:0]         mag_t;
    typedef logic signed [DATA_WIDTH-1:0] coef_t;
    typedef logic [CNT_WIDTH-1:0]         cnt_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture operands, set up coefficients
        logic div_start; // clear quotient, remainder and accumulators, preset the bit counter
        logic div_step;  // one restoring division step
        logic upd_step;  // one multiply-accumulate step of the coefficient update
        logic finish;    // rotate the remainder and coefficient registers
    } egcd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic rem_zero;  // current remainder is zero
        logic div_last;  // division on its final bit
        logic upd_last;  // coefficient update on its final bit
    } egcd_stat_t;

    // magnitude with the most negative value clamped
    function automatic mag_t mag_of(input coef_t v);
        logic [DATA_WIDTH-1:0] n;
        begin
            n = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
            if (n[DATA_WIDTH-1])
                mag_of = {MAG_WIDTH{1'b1}};
            else
                mag_of = n[MAG_WIDTH-1:0];
        end
    endfunction

endpackage

// File: design/extended_gcd_unit.sv
// top level of the extended gcd unit
//   channel | dir | tdata fields (lsb first)
//   s_axis  | in  | operand_a[31:0], operand_b[63:32]
//   m_axis  | out | gcd_value[30:0], coef_larger[62:31], coef_smaller[94:63], pad to 96
// each round is a remainder test, 31 division steps then
// 31 coefficient steps through one bit-serial unit
// a word passes through idle, the rounds, a final remainder test and done
// reset clears the controller and the bit counter; result registers hold garbage until loaded
// s_axis_tready is high only when idle; the result holds until m_axis_tready
module extended_gcd_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata   // gcd_value, coef_larger, coef_smaller, zero pad
);
    import egcd_pkg::*;

    egcd_cmd_t  cmd;
    egcd_stat_t stat;
    logic       idle, done, in_fire, out_fire;
    mag_t       gcd_value;
    coef_t      coef_larger, coef_smaller;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    egcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle),
        .done     (done)
    );

    egcd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operand_a    (s_axis_tdata[DATA_WIDTH-1:0]),
        .operand_b    (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .stat         (stat),
        .gcd_value    (gcd_value),
        .coef_larger  (coef_larger),
        .coef_smaller (coef_smaller)
    );

    assign s_axis_tready = idle;
    assign m_axis_tvalid = done;
    assign m_axis_tdata  = {1'b0, coef_smaller, coef_larger, gcd_value};

`ifndef SYNTH
    // no word is taken while a result is pending
    a_no_accept_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // a delivered result returns the unit to idle
    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("not idle after result");

    // an accepted word never yields a result in the next cycle
    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");
`endif

endmodule

// File: design/egcd_ctrl.sv
// control state machine of the extended gcd unit
module egcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_fire,
    input  egcd_pkg::egcd_stat_t stat,
    output egcd_pkg::egcd_cmd_t  cmd,
    output logic               idle,
    output logic               done
);
    import egcd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TEST = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (stat.rem_zero)
                    state_next = ST_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd_step = 1'b1;
                if (stat.upd_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_DONE:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// File: design/egcd_datapath.sv
// remainder, quotient and coefficient registers with a shared bit-serial step
module egcd_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  egcd_pkg::egcd_cmd_t    cmd,
    input  egcd_pkg::coef_t        operand_a,
    input  egcd_pkg::coef_t        operand_b,
    output egcd_pkg::egcd_stat_t   stat,
    output egcd_pkg::mag_t         gcd_value,
    output egcd_pkg::coef_t        coef_larger,
    output egcd_pkg::coef_t        coef_smaller
);
    import egcd_pkg::*;

    mag_t  prev_r_reg, cur_r_reg, quo_reg, rem_reg;
    coef_t prev_x_reg, cur_x_reg, prev_y_reg, cur_y_reg;
    coef_t acc_x_reg, acc_y_reg;
    cnt_t  cnt_reg;

    mag_t  mag_a, mag_b;
    logic [MAG_WIDTH:0] trial;
    logic  qbit;
    coef_t add_x, add_y;

    assign mag_a = mag_of(operand_a);
    assign mag_b = mag_of(operand_b);

    // restoring division: shift in the next dividend bit, subtract the divisor
    assign trial = {rem_reg, prev_r_reg[cnt_reg]} - {1'b0, cur_r_reg};

    // quotient bit for the msb-first shift-and-add of q * cur coefficients
    assign qbit  = quo_reg[cnt_reg];
    assign add_x = qbit ? cur_x_reg : '0;
    assign add_y = qbit ? cur_y_reg : '0;

    // counter, no reset needed for payload; counter is control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_start)
            cnt_reg <= cnt_t'(MAG_WIDTH - 1);
        else if (cmd.div_step || cmd.upd_step)
        begin
            if (cnt_reg == '0)
                cnt_reg <= cnt_t'(MAG_WIDTH - 1);
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prev_r_reg <= (mag_b > mag_a) ? mag_b : mag_a;
            cur_r_reg  <= (mag_b > mag_a) ? mag_a : mag_b;
            prev_x_reg <= coef_t'(1);
            cur_x_reg  <= '0;
            prev_y_reg <= '0;
            cur_y_reg  <= coef_t'(1);
        end
        else if (cmd.div_start)
        begin
            rem_reg   <= '0;
            quo_reg   <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[MAG_WIDTH])
            begin
                rem_reg          <= trial[MAG_WIDTH-1:0];
                quo_reg[cnt_reg] <= 1'b1;
            end
            else
                rem_reg <= {rem_reg[MAG_WIDTH-2:0], prev_r_reg[cnt_reg]};
        end
        else if (cmd.upd_step)
        begin
            acc_x_reg <= (acc_x_reg <<< 1) + add_x;
            acc_y_reg <= (acc_y_reg <<< 1) + add_y;
            if (cmd.finish)
            begin
                prev_r_reg <= cur_r_reg;
                cur_r_reg  <= rem_reg;
                prev_x_reg <= cur_x_reg;
                cur_x_reg  <= prev_x_reg - ((acc_x_reg <<< 1) + add_x);
                prev_y_reg <= cur_y_reg;
                cur_y_reg  <= prev_y_reg - ((acc_y_reg <<< 1) + add_y);
            end
        end
    end

    assign stat.rem_zero = (cur_r_reg == '0);
    assign stat.div_last = (cnt_reg == '0);
    assign stat.upd_last = (cnt_reg == '0);

    assign gcd_value    = prev_r_reg;
    assign coef_larger  = prev_x_reg;
    assign coef_smaller = prev_y_reg;

endmodule

// File: dv/extended_gcd_unit_tb.sv
// testbench for the extended gcd unit: random and directed operand pairs checked against a predictor
module extended_gcd_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import egcd_pkg::*;

    typedef struct {
        logic [30:0]        gcd_value;
        logic signed [31:0] coef_larger;
        logic signed [31:0] coef_smaller;
    } bezout_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    logic [63:0] operand_queue[$];
    bezout_t     bezout_queue[$];
    int          error_count;
    int          burst_left;
    int          gap_left;
    int          hold_cycles;
    int          stall_phase;
    logic        stimulus_done;
    logic        sender_pause;

    extended_gcd_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // operand_a, operand_b
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // gcd_value, coef_larger, coef_smaller, zero pad
    );

    // magnitude with the most negative value clamped to the largest magnitude
    function automatic logic [30:0] clamp_mag(input logic [31:0] v);
        logic [31:0] n;
        begin
            n = v[31] ? (~v + 32'd1) : v;
            clamp_mag = n[31] ? 31'h7fff_ffff : n[30:0];
        end
    endfunction

    // iterative extended euclid on the ordered magnitudes
    function automatic bezout_t solve_bezout(input logic [63:0] word);
        logic [63:0] big, little, tmp, q, r_prev, r_cur, r_next;
        logic [63:0] x_prev, x_cur, x_next, y_prev, y_cur, y_next;
        bezout_t res;
        begin
            big    = {33'd0, clamp_mag(word[31:0])};
            little = {33'd0, clamp_mag(word[63:32])};
            if (little > big)
            begin
                tmp = big;
                big = little;
                little = tmp;
            end
            r_prev = big;   r_cur = little;
            x_prev = 64'd1; x_cur = 64'd0;
            y_prev = 64'd0; y_cur = 64'd1;
            while (r_cur != 0)
            begin
                q      = r_prev / r_cur;
                r_next = r_prev % r_cur;
                x_next = x_prev - q * x_cur;
                y_next = y_prev - q * y_cur;
                r_prev = r_cur; r_cur = r_next;
                x_prev = x_cur; x_cur = x_next;
                y_prev = y_cur; y_cur = y_next;
            end
            res.gcd_value    = r_prev[30:0];
            res.coef_larger  = x_prev[31:0];
            res.coef_smaller = y_prev[31:0];
            solve_bezout = res;
        end
    endfunction

    function automatic logic [31:0] rand_operand();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: rand_operand = $urandom_range(0, 20);
                1: rand_operand = -$urandom_range(0, 20);
                2: rand_operand = $urandom_range(0, 5000) * 32'd6;
                3: rand_operand = 32'h8000_0000 + $urandom_range(0, 3);
                4: rand_operand = 32'h7fff_ffff - $urandom_range(0, 3);
                default: rand_operand = $urandom;
            endcase
        end
    endfunction

    function automatic logic [63:0] rand_pair();
        logic [31:0] a, b;
        int k;
        begin
            a = rand_operand();
            b = rand_operand();
            // consecutive fibonacci pairs give the longest round counts
            if ($urandom_range(0, 15) == 0)
            begin
                a = 1; b = 1;
                k = $urandom_range(2, 44);
                repeat (k)
                begin
                    b = a + b;
                    a = b - a;
                end
                if ($urandom_range(0, 1) == 1) a = -a;
            end
            rand_pair = {b, a};
        end
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset and stimulus
    initial
    begin
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        sender_pause = 1'b0;
        error_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed pairs
        operand_queue.push_back({32'd0, 32'd0});
        operand_queue.push_back({32'd0, 32'd17});
        operand_queue.push_back({32'hffff_ffef, 32'd0});
        operand_queue.push_back({32'd12, 32'd12});
        operand_queue.push_back({32'hffff_fff4, 32'd12});
        operand_queue.push_back({32'h8000_0000, 32'h7fff_ffff});
        operand_queue.push_back({32'h7fff_ffff, 32'h8000_0000});
        operand_queue.push_back({32'h8000_0000, 32'h8000_0000});
        operand_queue.push_back({32'h8000_0001, 32'd1});
        operand_queue.push_back({32'd1, 32'h7fff_ffff});
        operand_queue.push_back({32'd1134903170, 32'd1836311903});
        operand_queue.push_back({32'd240, 32'd46});
        operand_queue.push_back({32'hffff_ffd2, 32'hffff_ff10});
        operand_queue.push_back({32'hffff_ffff, 32'hffff_ffff});
        operand_queue.push_back({32'd7, 32'd3});
        operand_queue.push_back({32'h5555_5555, 32'haaaa_aaaa});

        // drain once before the random part
        wait (operand_queue.size() == 0);
        sender_pause = 1'b1;
        wait (bezout_queue.size() == 0 && !m_axis_tvalid);
        sender_pause = 1'b0;

        repeat (400) operand_queue.push_back(rand_pair());
        stimulus_done = 1'b1;
    end

    // sender: bursts of words with random gaps, the queue head is the word on the bus
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                bezout_queue.push_back(solve_bezout(s_axis_tdata));
                void'(operand_queue.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (!sender_pause && operand_queue.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= operand_queue[0];
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= 0;
            stall_phase   <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stimulus_done && hold_cycles < 20000)
            begin
                hold_cycles   <= hold_cycles + 1;
                m_axis_tready <= 1'b0;
            end
            else if ((stall_phase / 500) % 4 == 3)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        bezout_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bezout_queue.size() == 0)
            begin
                $error("result word with no expectation: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = bezout_queue.pop_front();
                if (m_axis_tdata[30:0] !== want.gcd_value)
                begin
                    $error("gcd_value expected %0d got %0d", want.gcd_value, m_axis_tdata[30:0]);
                    error_count++;
                end
                if (m_axis_tdata[62:31] !== want.coef_larger)
                begin
                    $error("coef_larger expected %0d got %0d", want.coef_larger,
                           $signed(m_axis_tdata[62:31]));
                    error_count++;
                end
                if (m_axis_tdata[94:63] !== want.coef_smaller)
                begin
                    $error("coef_smaller expected %0d got %0d", want.coef_smaller,
                           $signed(m_axis_tdata[94:63]));
                    error_count++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stimulus_done && operand_queue.size() == 0 && !s_axis_tvalid);
        wait (bezout_queue.size() == 0);
        repeat (3000) @(posedge clk);
        if (error_count == 0 && bezout_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // timeout
    initial
    begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
